// File: rtl/core/tpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants for the trigger prescale counter.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int NUM_TRIGGERS   = 64;
  localparam int NUM_COLUMNS    = 6;
  localparam int NUM_GROUPS     = 7;
  localparam int COUNT_WIDTH    = 32;
  localparam int PRESCALE_WIDTH = 16;
  localparam int NUM_REGS       = 7;
  localparam int NUM_PS         = NUM_TRIGGERS * NUM_COLUMNS;
  localparam int NUM_GC         = NUM_GROUPS * NUM_COLUMNS;

  localparam int TW  = 6;
  localparam int CW  = 3;
  localparam int GW  = 3;
  localparam int PSA = $clog2(NUM_PS);
  localparam int GCA = $clog2(NUM_GC);

  typedef logic [1:0] op_t;
  localparam op_t OP_EVENT  = 2'd0;
  localparam op_t OP_WRITE  = 2'd1;
  localparam op_t OP_READ   = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_RAW   = 2'd0;
  localparam sel_t SEL_TRCOL = 2'd1;
  localparam sel_t SEL_COL   = 2'd2;
  localparam sel_t SEL_GRP   = 2'd3;

  localparam logic [1:0] ST_EVENT = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  typedef logic [COUNT_WIDTH-1:0]    cnt_t;
  typedef logic [PRESCALE_WIDTH-1:0] ps_t;

  // request to the modulo unit and its answer
  typedef struct packed {
    logic start;
    cnt_t dividend;
    ps_t  divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_rsp_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == '1) ? c : c + cnt_t'(1);
  endfunction

endpackage

// File: rtl/core/trigger_prescale_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trigger_prescale_counter
// Prescales fired triggers per column, keeps saturating fire counters.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_     | input     | in_valid / in_ready
//  out_    | output    | out_valid / out_ready
//  cfg_    | input     | cfg_we, no wait
//
// After reset a clearing pass zeroes the table and counters; no item is
// taken meanwhile. An event walks every fired trigger and column through
// one shared modulo unit, skipping it for a pair with a zero prescale,
// which never passes, then walks the 42 group/column counters, reading
// each and writing it back bumped where it accepted. A write goes straight
// to the result; a read first passes S_READ and S_READ2. One item at a
// time; the block waits for out_ready before taking the next.
// ----------------------------------------------------------------------------
module trigger_prescale_counter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [63:0]         in_fired_bits,
  input  logic [5:0]          in_trigger_index,
  input  logic [2:0]          in_column_index,
  input  logic [15:0]         in_prescale_value,
  input  logic [1:0]          in_counter_select,
  input  logic [2:0]          in_group_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [5:0]          out_column_accepts,
  output logic [41:0]         out_group_accepts,
  output logic [31:0]         out_count_value,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import tpc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TRIG, S_PSRD, S_PSWAIT, S_MODGO, S_MODWAIT, S_PCUPD,
    S_RAWUPD, S_TOTALS, S_GCRD, S_GCUPD, S_READ, S_READ2, S_OUT
  } state_t;

  // memories
  ps_t  ps_mem   [NUM_PS];
  cnt_t pc_mem   [NUM_PS];
  cnt_t raw_mem  [NUM_TRIGGERS];
  cnt_t gc_mem   [NUM_GC];
  cnt_t col_cnt_r[NUM_COLUMNS];
  logic [63:0] mask_r [NUM_REGS];

  state_t          state_r;
  logic [PSA-1:0]  clr_r;
  logic [63:0]     fired_r;
  logic [TW-1:0]   t_r;
  logic [CW-1:0]   c_r;
  logic [PSA-1:0]  base_r;
  ps_t             ps_q;
  cnt_t            pc_q, raw_q, rd_q, gc_q;
  logic [5:0]      cacc_r;
  logic [41:0]     gacc_r;
  logic [1:0]      status_r;
  logic [31:0]     val_r;
  logic [PSA-1:0]  wa_r;
  logic [GCA-1:0]  gca_r;
  sel_t            sel_r;
  logic [TW-1:0]   ti_r;
  logic [CW-1:0]   ci_r;
  logic [GW-1:0]   gi_r;
  logic            pass_r;
  logic [CW-1:0]   col_sel;
  logic [GW-1:0]   grp_sel;
  logic [PSA-1:0]  addr;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  tpc_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  assign mreq.start    = (state_r == S_MODGO);
  assign mreq.dividend = raw_q;
  assign mreq.divisor  = ps_q;

  assign addr = base_r + PSA'(c_r);

  // out-of-range read indexes fall back to entry 0; the value is masked later
  assign col_sel = (in_column_index < CW'(NUM_COLUMNS)) ? in_column_index : '0;
  assign grp_sel = (in_group_index < GW'(NUM_GROUPS)) ? in_group_index : '0;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_status         = status_r;
  assign out_column_accepts = cacc_r;
  assign out_group_accepts  = gacc_r;
  assign out_count_value    = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NUM_REGS; g++) mask_r[g] <= '0;
    end else if (cfg_we && cfg_index < 3'(NUM_REGS)) begin
      mask_r[cfg_index] <= cfg_data;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    ps_q <= ps_mem[addr];
    pc_q <= pc_mem[addr];
    rd_q <= pc_mem[wa_r];
    gc_q <= gc_mem[gca_r];
    if (state_r == S_CLEAR) begin
      ps_mem[clr_r] <= '0;
      pc_mem[clr_r] <= '0;
      if (clr_r < PSA'(NUM_TRIGGERS)) raw_mem[clr_r[TW-1:0]] <= '0;
      if (clr_r < PSA'(NUM_GC)) gc_mem[clr_r[GCA-1:0]] <= '0;
    end else if (state_r == S_IDLE && in_valid && in_op == OP_WRITE) begin
      if (in_column_index < 3'(NUM_COLUMNS))
        ps_mem[PSA'(in_trigger_index) * PSA'(NUM_COLUMNS) + PSA'(in_column_index)]
          <= in_prescale_value;
    end else if (state_r == S_PCUPD && pass_r) begin
      pc_mem[addr] <= sat_inc(pc_q);
    end else if (state_r == S_RAWUPD) begin
      raw_mem[t_r] <= sat_inc(raw_q);
    end
    if (state_r == S_GCUPD && gacc_r[gca_r]) gc_mem[gca_r] <= sat_inc(gc_q);
    if (state_r == S_TRIG || state_r == S_READ)
      raw_q <= raw_mem[(state_r == S_READ) ? ti_r : t_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      for (int i = 0; i < NUM_COLUMNS; i++) col_cnt_r[i] <= '0;
    end else begin
      pass_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + PSA'(1);
          if (clr_r == PSA'(NUM_PS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          sel_r  <= in_counter_select;
          ti_r   <= in_trigger_index;
          ci_r   <= in_column_index;
          gi_r   <= in_group_index;
          wa_r   <= PSA'(in_trigger_index) * PSA'(NUM_COLUMNS) + PSA'(col_sel);
          gca_r  <= GCA'(grp_sel) * GCA'(NUM_COLUMNS) + GCA'(col_sel);
          fired_r <= in_fired_bits;
          t_r    <= '0;
          c_r    <= '0;
          base_r <= '0;
          cacc_r <= '0;
          gacc_r <= '0;
          val_r  <= '0;
          unique case (in_op)
            OP_EVENT: begin status_r <= ST_EVENT; state_r <= S_TRIG; end
            OP_WRITE: begin status_r <= ST_WRITE; state_r <= S_OUT; end
            OP_READ:  begin status_r <= ST_READ;  state_r <= S_READ; end
            default:  begin status_r <= ST_EVENT; state_r <= S_OUT; end
          endcase
        end
        S_TRIG: begin
          c_r <= '0;
          if (fired_r[t_r]) state_r <= S_PSRD;
          else if (t_r == TW'(NUM_TRIGGERS - 1)) state_r <= S_TOTALS;
          else begin
            t_r    <= t_r + TW'(1);
            base_r <= base_r + PSA'(NUM_COLUMNS);
          end
        end
        S_PSRD:   state_r <= S_PSWAIT;
        S_PSWAIT: state_r <= (ps_q == '0) ? S_PCUPD : S_MODGO;
        S_MODGO:  state_r <= S_MODWAIT;
        S_MODWAIT: if (mrsp.done) begin
          if (mrsp.zero) begin
            pass_r <= 1'b1;
            cacc_r[c_r] <= 1'b1;
            for (int g = 0; g < NUM_GROUPS; g++)
              if (mask_r[g][t_r]) gacc_r[g*NUM_COLUMNS + int'(c_r)] <= 1'b1;
          end
          state_r <= S_PCUPD;
        end
        S_PCUPD: begin
          if (c_r == CW'(NUM_COLUMNS - 1)) state_r <= S_RAWUPD;
          else begin
            c_r <= c_r + CW'(1);
            state_r <= S_PSRD;
          end
        end
        S_RAWUPD: begin
          if (t_r == TW'(NUM_TRIGGERS - 1)) state_r <= S_TOTALS;
          else begin
            t_r    <= t_r + TW'(1);
            base_r <= base_r + PSA'(NUM_COLUMNS);
            state_r <= S_TRIG;
          end
        end
        S_TOTALS: begin
          for (int c = 0; c < NUM_COLUMNS; c++)
            if (cacc_r[c]) col_cnt_r[c] <= sat_inc(col_cnt_r[c]);
          gca_r   <= '0;
          state_r <= S_GCRD;
        end
        // group/column counters: read one entry, then bump it if that group/column accepted
        S_GCRD: state_r <= S_GCUPD;
        S_GCUPD: begin
          if (gca_r == GCA'(NUM_GC - 1)) state_r <= S_OUT;
          else begin
            gca_r   <= gca_r + GCA'(1);
            state_r <= S_GCRD;
          end
        end
        S_READ: state_r <= S_READ2;
        S_READ2: begin
          unique case (sel_r)
            SEL_RAW:   val_r <= raw_q;
            SEL_TRCOL: val_r <= (ci_r < CW'(NUM_COLUMNS)) ? rd_q : '0;
            SEL_COL:   val_r <= (ci_r < CW'(NUM_COLUMNS)) ? col_cnt_r[ci_r] : '0;
            SEL_GRP:   val_r <= (ci_r < CW'(NUM_COLUMNS) && gi_r < GW'(NUM_GROUPS))
                                ? gc_q : '0;
            default:   val_r <= '0;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/tpc_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_mod_unit
// Restoring remainder unit: tests dividend mod divisor == 0, one bit a cycle.
// ----------------------------------------------------------------------------
module tpc_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  tpc_pkg::mod_req_t req,
  output tpc_pkg::mod_rsp_t rsp
);
  import tpc_pkg::*;

  localparam int BW = $clog2(COUNT_WIDTH + 1);

  cnt_t                  quo_r, quo_nxt;
  logic [PRESCALE_WIDTH:0] rem_r, rem_nxt;
  ps_t                   div_r, div_nxt;
  logic [BW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [PRESCALE_WIDTH:0] sh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[PRESCALE_WIDTH-1:0], quo_r[COUNT_WIDTH-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = BW'(COUNT_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[COUNT_WIDTH-2:0], 1'b0};
      if (sh >= {1'b0, div_r}) rem_nxt = sh - {1'b0, div_r};
      else rem_nxt = sh;
      cnt_nxt = cnt_r - BW'(1);
      if (cnt_r == BW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

// File: tb/sv/tb_trigger_prescale_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trigger_prescale_counter
// Drives events, prescale writes, counter reads and unused op codes into the
// prescale counter, predicts each result from a local copy of the table,
// masks and counters unless a directed item carries its own, and checks each
// result in order. Group masks change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_trigger_prescale_counter;
  import tpc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  col_acc;
    logic [41:0] grp_acc;
    logic [31:0] value;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] fired;
    logic [5:0]  trig;
    logic [2:0]  col;
    logic [15:0] ps;
    sel_t        sel;
    logic [2:0]  grp;
    logic        typed;
    result_t     res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [63:0] in_fired_bits;
  logic [5:0]  in_trigger_index;
  logic [2:0]  in_column_index;
  logic [15:0] in_prescale_value;
  logic [1:0]  in_counter_select;
  logic [2:0]  in_group_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [5:0]  out_column_accepts;
  logic [41:0] out_group_accepts;
  logic [31:0] out_count_value;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  trigger_prescale_counter i_dut (.*);

  // local copy of the block's state
  logic [63:0] group_mask [NUM_GROUPS];
  ps_t         ps_table   [NUM_PS];
  cnt_t        raw_cnt    [NUM_TRIGGERS];
  cnt_t        trcol_cnt  [NUM_PS];
  cnt_t        col_total  [NUM_COLUMNS];
  cnt_t        grpcol_cnt [NUM_GC];

  result_t pending_results [$];
  row_t    directed [20];
  logic    typed_pending;
  result_t typed_result;
  int      errors;
  int      ready_mode;
  int      ready_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #1s;
    $display("tb_trigger_prescale_counter NOT OK");
    $finish;
  end

  function automatic cnt_t bump(input cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // applies one accepted item to the local state and returns its result
  task automatic count_item(input row_t it, output result_t r);
    logic [5:0]  cacc;
    logic [41:0] gacc;
    int          idx;
    r = '0;
    cacc = '0;
    gacc = '0;
    case (it.op)
      OP_EVENT: begin
        for (int t = 0; t < NUM_TRIGGERS; t++) begin
          if (it.fired[t]) begin
            for (int c = 0; c < NUM_COLUMNS; c++) begin
              idx = t * NUM_COLUMNS + c;
              if (ps_table[idx] != 0 && (raw_cnt[t] % ps_table[idx]) == 0) begin
                cacc[c] = 1'b1;
                trcol_cnt[idx] = bump(trcol_cnt[idx]);
                for (int g = 0; g < NUM_GROUPS; g++)
                  if (group_mask[g][t]) gacc[g * NUM_COLUMNS + c] = 1'b1;
              end
            end
            raw_cnt[t] = bump(raw_cnt[t]);
          end
        end
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          if (cacc[c]) col_total[c] = bump(col_total[c]);
          for (int g = 0; g < NUM_GROUPS; g++)
            if (gacc[g * NUM_COLUMNS + c])
              grpcol_cnt[g * NUM_COLUMNS + c] = bump(grpcol_cnt[g * NUM_COLUMNS + c]);
        end
        r.status  = ST_EVENT;
        r.col_acc = cacc;
        r.grp_acc = gacc;
      end
      OP_WRITE: begin
        if (it.col < NUM_COLUMNS) ps_table[it.trig * NUM_COLUMNS + it.col] = it.ps;
        r.status = ST_WRITE;
      end
      OP_READ: begin
        r.status = ST_READ;
        case (it.sel)
          SEL_RAW:   r.value = raw_cnt[it.trig];
          SEL_TRCOL: if (it.col < NUM_COLUMNS) r.value = trcol_cnt[it.trig * NUM_COLUMNS + it.col];
          SEL_COL:   if (it.col < NUM_COLUMNS) r.value = col_total[it.col];
          default:   if (it.col < NUM_COLUMNS && it.grp < NUM_GROUPS)
                       r.value = grpcol_cnt[it.grp * NUM_COLUMNS + it.col];
        endcase
      end
      default: r = '0;  // unused op code: no effect
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, exp);
    errors++;
  endtask

  // accept side: predict; result side: compare
  always @(posedge clk) begin
    row_t    it;
    result_t r;
    result_t e;
    if (rst_n && in_valid && in_ready) begin
      it = '0;
      it.op = in_op;
      it.fired = in_fired_bits;
      it.trig = in_trigger_index;
      it.col = in_column_index;
      it.ps = in_prescale_value;
      it.sel = in_counter_select;
      it.grp = in_group_index;
      count_item(it, r);
      pending_results = {pending_results, (typed_pending ? typed_result : r)};
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected item", out_status, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_column_accepts !== e.col_acc)
          report("column_accepts", out_column_accepts, e.col_acc);
        if (out_group_accepts !== e.grp_acc)
          report("group_accepts", out_group_accepts, e.grp_acc);
        if (out_count_value !== e.value) report("count_value", out_count_value, e.value);
      end
    end
  end

  // receiver stall pattern: always ready, mostly ready, mostly stalled
  always @(negedge clk) begin
    if (ready_cnt == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_cnt  <= $urandom_range(20, 300);
    end else begin
      ready_cnt <= ready_cnt - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic row_t mk(input op_t op, input logic [63:0] fired, input logic [5:0] trig,
                              input logic [2:0] col, input logic [15:0] ps, input sel_t sel,
                              input logic [2:0] grp, input logic typed,
                              input logic [1:0] st, input logic [31:0] val);
    row_t r;
    r = '0;
    r.op = op; r.fired = fired; r.trig = trig; r.col = col; r.ps = ps;
    r.sel = sel; r.grp = grp; r.typed = typed;
    r.res.status = st;
    r.res.value = val;
    return r;
  endfunction

  // one write, then the port is left idle before returning
  task automatic write_mask(input int idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data  <= val;
    group_mask[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // drives one item at a falling edge and waits for its acceptance
  task automatic put_item(input row_t it);
    in_valid          <= 1'b1;
    in_op             <= it.op;
    in_fired_bits     <= it.fired;
    in_trigger_index  <= it.trig;
    in_column_index   <= it.col;
    in_prescale_value <= it.ps;
    in_counter_select <= it.sel;
    in_group_index    <= it.grp;
    typed_pending     <= it.typed;
    typed_result      <= it.res;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    typed_pending <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic row_t rand_item;
    row_t    r;
    int      pick;
    int      n;
    r = '0;
    pick = $urandom_range(0, 99);
    r.trig = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    r.col  = 3'($urandom_range(0, 7));
    r.grp  = 3'($urandom_range(0, 7));
    r.sel  = sel_t'($urandom_range(0, 3));
    if (pick < 50) begin
      r.op = OP_EVENT;
      if ($urandom_range(0, 99) == 0) begin
        r.fired = {$urandom, $urandom};
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) r.fired[$urandom_range(0, 63)] = 1'b1;
          else r.fired[$urandom_range(0, 7)] = 1'b1;
        end
      end
    end else if (pick < 70) begin
      r.op = OP_WRITE;
      n = $urandom_range(0, 19);
      if (n < 12)      r.ps = 16'($urandom_range(1, 4));
      else if (n < 15) r.ps = '0;
      else if (n < 17) r.ps = '1;
      else             r.ps = 16'($urandom);
    end else if (pick < 95) begin
      r.op = OP_READ;
    end else begin
      r.op = OP_UNUSED;
      r.fired = {$urandom, $urandom};
      r.ps = 16'($urandom);
    end
    if ($urandom_range(0, 9) == 0) r.fired = r.fired | {$urandom, $urandom};
    return r;
  endfunction

  task automatic random_phase(input int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end
      end
      put_item(rand_item());
      burst--;
    end
  endtask

  initial begin
    errors = 0;
    ready_mode = 0;
    ready_cnt = 0;
    typed_pending = 1'b0;
    typed_result = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_EVENT;
    in_fired_bits = '0;
    in_trigger_index = '0;
    in_column_index = '0;
    in_prescale_value = '0;
    in_counter_select = SEL_RAW;
    in_group_index = '0;
    out_ready = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int g = 0; g < NUM_GROUPS; g++) group_mask[g] = '0;
    for (int i = 0; i < NUM_PS; i++) begin
      ps_table[i] = '0;
      trcol_cnt[i] = '0;
    end
    for (int t = 0; t < NUM_TRIGGERS; t++) raw_cnt[t] = '0;
    for (int c = 0; c < NUM_COLUMNS; c++) col_total[c] = '0;
    for (int i = 0; i < NUM_GC; i++) grpcol_cnt[i] = '0;

    directed[0]  = mk(OP_READ,  '0, 6'd0,  3'd0, 16'd0, SEL_RAW, 3'd0, 1, ST_READ, 0);
    directed[1]  = mk(OP_EVENT, '1, 6'd0,  3'd0, 16'd0, SEL_RAW, 3'd0, 1, ST_EVENT, 0);
    directed[2]  = mk(OP_READ,  '0, 6'd63, 3'd0, 16'd0, SEL_RAW, 3'd0, 1, ST_READ, 1);
    directed[3]  = mk(OP_WRITE, '0, 6'd0,  3'd0, 16'd1, SEL_RAW, 3'd0, 1, ST_WRITE, 0);
    directed[4]  = mk(OP_WRITE, '0, 6'd63, 3'd5, 16'hffff, SEL_RAW, 3'd0, 1, ST_WRITE, 0);
    // column outside the table: write dropped, status still reported
    directed[5]  = mk(OP_WRITE, '0, 6'd5,  3'd6, 16'd3, SEL_RAW, 3'd0, 1, ST_WRITE, 0);
    directed[6]  = mk(OP_WRITE, '0, 6'd1,  3'd2, 16'd2, SEL_RAW, 3'd0, 0, 0, 0);
    directed[7]  = mk(OP_EVENT, 64'h8000_0000_0000_0023, 6'd0, 3'd0, 16'd0, SEL_RAW, 3'd0,
                      0, 0, 0);
    directed[8]  = mk(OP_EVENT, 64'h2, 6'd0, 3'd0, 16'd0, SEL_RAW, 3'd0, 0, 0, 0);
    directed[9]  = mk(OP_EVENT, 64'h2, 6'd0, 3'd0, 16'd0, SEL_RAW, 3'd0, 0, 0, 0);
    directed[10] = mk(OP_READ,  '0, 6'd0,  3'd0, 16'd0, SEL_TRCOL, 3'd0, 0, 0, 0);
    directed[11] = mk(OP_READ,  '0, 6'd0,  3'd2, 16'd0, SEL_COL, 3'd0, 0, 0, 0);
    directed[12] = mk(OP_READ,  '0, 6'd0,  3'd0, 16'd0, SEL_GRP, 3'd6, 0, 0, 0);
    directed[13] = mk(OP_READ,  '0, 6'd0,  3'd0, 16'd0, SEL_GRP, 3'd7, 1, ST_READ, 0);
    directed[14] = mk(OP_READ,  '0, 6'd0,  3'd7, 16'd0, SEL_TRCOL, 3'd0, 1, ST_READ, 0);
    directed[15] = mk(OP_READ,  '0, 6'd0,  3'd6, 16'd0, SEL_COL, 3'd0, 1, ST_READ, 0);
    // unused op code: everything zero
    directed[16] = mk(OP_UNUSED, '1, 6'd63, 3'd7, 16'hffff, SEL_GRP, 3'd7, 1, ST_EVENT, 0);
    directed[17] = mk(OP_WRITE, '0, 6'd0,  3'd0, 16'd0, SEL_RAW, 3'd0, 0, 0, 0);
    directed[18] = mk(OP_EVENT, 64'h1, 6'd0, 3'd0, 16'd0, SEL_RAW, 3'd0, 0, 0, 0);
    directed[19] = mk(OP_EVENT, '1, 6'd0, 3'd0, 16'd0, SEL_RAW, 3'd0, 0, 0, 0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    write_mask(0, '1);
    write_mask(1, '0);
    for (int g = 2; g < NUM_GROUPS; g++) write_mask(g, {$urandom, $urandom});
    foreach (directed[i]) put_item(directed[i]);
    drain();

    // hot triggers get small prescales so passes are frequent
    for (int t = 0; t < 8; t++)
      for (int c = 0; c < NUM_COLUMNS; c++)
        put_item(mk(OP_WRITE, '0, 6'(t), 3'(c), 16'($urandom_range(1, 3)), SEL_RAW, 3'd0,
                    0, 0, 0));
    random_phase(220);
    drain();

    for (int g = 0; g < NUM_GROUPS; g++) write_mask(g, '1);
    random_phase(220);
    drain();

    for (int g = 0; g < NUM_GROUPS; g++)
      write_mask(g, {$urandom, $urandom} & {$urandom, $urandom});
    write_mask(3, '0);
    random_phase(220);
    drain();

    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("tb_trigger_prescale_counter OK");
    end else begin
      $display("tb_trigger_prescale_counter NOT OK");
    end
    $finish;
  end

endmodule
